[sv/isots_pkg.sv]
// shared types, character codes and constants for the timestamp to epoch converter
package isots_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned FIELD_W = 7;
  localparam int unsigned FRAC_W  = 10;
  localparam int unsigned FDIG_W  = 2;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;

  localparam logic [63:0] FAIL_HIGH_VALUE = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [FDIG_W-1:0] FRAC_DIGITS_MAX = 2'd3;

  // position in YYYY-MM-DDTHH:MM:SS[.f+](Z|+HH:MM|-HH:MM)
  typedef enum logic [4:0] {
    PH_Y0, PH_Y1, PH_Y2, PH_Y3, PH_DASH1, PH_MO0, PH_MO1, PH_DASH2,
    PH_D0, PH_D1, PH_T, PH_H0, PH_H1, PH_COLON1, PH_MI0, PH_MI1,
    PH_COLON2, PH_S0, PH_S1, PH_SEP, PH_FRAC0, PH_FRAC, PH_ZH0, PH_ZH1,
    PH_ZCOLON, PH_ZM0, PH_ZM1, PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_ERA, BK_YOE, BK_DOE, BK_DAYS, BK_MUL, BK_SUM
  } back_state_t;

  // one parsed timestamp handed from the parser to the converter
  typedef struct packed {
    logic               ok;
    logic               fail_high;
    logic [YEAR_W-1:0]  year;
    logic [FIELD_W-1:0] month;
    logic [FIELD_W-1:0] day;
    logic [FIELD_W-1:0] hour;
    logic [FIELD_W-1:0] minute;
    logic [FIELD_W-1:0] second;
    logic [FRAC_W-1:0]  frac_ms;
    logic [FDIG_W-1:0]  frac_digits;
    logic               zone_neg;
    logic [FIELD_W-1:0] zone_hours;
    logic [FIELD_W-1:0] zone_minutes;
  } stamp_t;

endpackage

[sv/isots_parser.sv]
// front end: checks the character stream and collects the decimal fields
module isots_parser import isots_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  input  logic       last_char,
  input  logic       fail_high,
  output logic       push,
  output stamp_t     stamp,
  input  logic       push_ready
);

  phase_t             phase, phase_next, phase_inc;
  logic [YEAR_W-1:0]  year, year_next;
  logic [FIELD_W-1:0] month, month_next, day, day_next;
  logic [FIELD_W-1:0] hour, hour_next, minute, minute_next, second, second_next;
  logic [FRAC_W-1:0]  frac_ms, frac_ms_next;
  logic [FDIG_W-1:0]  frac_digits, frac_digits_next;
  logic               zone_neg, zone_neg_next;
  logic [FIELD_W-1:0] zone_hours, zone_hours_next, zone_minutes, zone_minutes_next;
  logic               failed, failed_next;
  logic               step_ok, is_digit, zone_hit, accept;
  logic [3:0]         dval;

  function automatic logic [FIELD_W-1:0] acc_field(logic [FIELD_W-1:0] v, logic [3:0] d);
    return FIELD_W'(v * FIELD_W'(10) + FIELD_W'(d));
  endfunction

  assign accept    = in_valid && in_ready;
  assign in_ready  = push_ready;
  assign push      = accept && last_char;
  assign is_digit  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign dval      = char_code[3:0];
  assign phase_inc = phase_t'(phase + 5'd1);
  assign zone_hit  = (char_code == CH_Z) || (char_code == CH_PLUS) || (char_code == CH_DASH);

  always_comb begin
    phase_next        = phase;
    year_next         = year;
    month_next        = month;
    day_next          = day;
    hour_next         = hour;
    minute_next       = minute;
    second_next       = second;
    frac_ms_next      = frac_ms;
    frac_digits_next  = frac_digits;
    zone_neg_next     = zone_neg;
    zone_hours_next   = zone_hours;
    zone_minutes_next = zone_minutes;
    failed_next       = failed;
    step_ok           = 1'b0;
    if (!failed) begin
      case (phase)
        PH_Y0, PH_Y1, PH_Y2, PH_Y3: begin
          if (is_digit) begin
            year_next  = YEAR_W'(year * YEAR_W'(10) + YEAR_W'(dval));
            phase_next = phase_inc;
            step_ok    = 1'b1;
          end
        end
        PH_DASH1, PH_DASH2: begin
          if (char_code == CH_DASH) begin
            phase_next = phase_inc;
            step_ok    = 1'b1;
          end
        end
        PH_MO0, PH_MO1: begin
          if (is_digit) begin
            month_next = acc_field(month, dval);
            phase_next = phase_inc;
            step_ok    = 1'b1;
          end
        end
        PH_D0, PH_D1: begin
          if (is_digit) begin
            day_next   = acc_field(day, dval);
            phase_next = phase_inc;
            step_ok    = 1'b1;
          end
        end
        PH_T: begin
          if (char_code == CH_T) begin
            phase_next = phase_inc;
            step_ok    = 1'b1;
          end
        end
        PH_H0, PH_H1: begin
          if (is_digit) begin
            hour_next  = acc_field(hour, dval);
            phase_next = phase_inc;
            step_ok    = 1'b1;
          end
        end
        PH_COLON1, PH_COLON2, PH_ZCOLON: begin
          if (char_code == CH_COLON) begin
            phase_next = phase_inc;
            step_ok    = 1'b1;
          end
        end
        PH_MI0, PH_MI1: begin
          if (is_digit) begin
            minute_next = acc_field(minute, dval);
            phase_next  = phase_inc;
            step_ok     = 1'b1;
          end
        end
        PH_S0, PH_S1: begin
          if (is_digit) begin
            second_next = acc_field(second, dval);
            phase_next  = phase_inc;
            step_ok     = 1'b1;
          end
        end
        PH_SEP, PH_FRAC0, PH_FRAC: begin
          if (phase == PH_SEP && char_code == CH_DOT) begin
            phase_next = PH_FRAC0;
            step_ok    = 1'b1;
          end else if (phase != PH_SEP && is_digit) begin
            // digits past the third are checked but dropped
            if (frac_digits != FRAC_DIGITS_MAX) begin
              frac_ms_next     = FRAC_W'(frac_ms * FRAC_W'(10) + FRAC_W'(dval));
              frac_digits_next = frac_digits + 2'd1;
            end
            phase_next = PH_FRAC;
            step_ok    = 1'b1;
          end else if (phase != PH_FRAC0 && zone_hit) begin
            step_ok = 1'b1;
            if (char_code == CH_Z) begin
              phase_next = PH_DONE;
            end else begin
              zone_neg_next = (char_code == CH_DASH);
              phase_next    = PH_ZH0;
            end
          end
        end
        PH_ZH0, PH_ZH1: begin
          if (is_digit) begin
            zone_hours_next = acc_field(zone_hours, dval);
            phase_next      = phase_inc;
            step_ok         = 1'b1;
          end
        end
        PH_ZM0, PH_ZM1: begin
          if (is_digit) begin
            zone_minutes_next = acc_field(zone_minutes, dval);
            phase_next        = phase_inc;
            step_ok           = 1'b1;
          end
        end
        default: begin
          step_ok = 1'b0;
        end
      endcase
      if (!step_ok) begin
        failed_next = 1'b1;
      end
    end
  end

  always_comb begin
    stamp.ok           = !failed_next && (phase_next == PH_DONE);
    stamp.fail_high    = fail_high;
    stamp.year         = year_next;
    stamp.month        = month_next;
    stamp.day          = day_next;
    stamp.hour         = hour_next;
    stamp.minute       = minute_next;
    stamp.second       = second_next;
    stamp.frac_ms      = frac_ms_next;
    stamp.frac_digits  = frac_digits_next;
    stamp.zone_neg     = zone_neg_next;
    stamp.zone_hours   = zone_hours_next;
    stamp.zone_minutes = zone_minutes_next;
  end

  // the last beat of a timestamp hands it over and starts the next one clean
  always_ff @(posedge clk) begin
    if (rst || push) begin
      phase        <= PH_Y0;
      year         <= '0;
      month        <= '0;
      day          <= '0;
      hour         <= '0;
      minute       <= '0;
      second       <= '0;
      frac_ms      <= '0;
      frac_digits  <= '0;
      zone_neg     <= 1'b0;
      zone_hours   <= '0;
      zone_minutes <= '0;
      failed       <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      year         <= year_next;
      month        <= month_next;
      day          <= day_next;
      hour         <= hour_next;
      minute       <= minute_next;
      second       <= second_next;
      frac_ms      <= frac_ms_next;
      frac_digits  <= frac_digits_next;
      zone_neg     <= zone_neg_next;
      zone_hours   <= zone_hours_next;
      zone_minutes <= zone_minutes_next;
      failed       <= failed_next;
    end
  end

endmodule

[sv/isots_queue.sv]
// short register queue of parsed timestamps between parser and converter
module isots_queue import isots_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  stamp_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output stamp_t out_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  stamp_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push, pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

endmodule

[sv/isots_convert.sv]
// back end: days-from-civil conversion of one parsed timestamp to epoch milliseconds
module isots_convert import isots_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  stamp_t      stamp,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ok,
  output logic [63:0] out_ms
);

  back_state_t         state, state_next;
  stamp_t              rec;
  logic signed [14:0]  y_s;
  logic [6:0]          madj;
  logic signed [5:0]   era;
  logic [13:0]         x5;
  logic [8:0]          yoe;
  logic [11:0]         a5;
  logic [31:0]         doe;
  logic [18:0]         tsec;
  logic [9:0]          ms_frac;
  logic [12:0]         off;
  logic signed [34:0]  days;
  logic signed [31:0]  tms;
  logic signed [63:0]  prod;
  logic                early, out_load;
  logic [27:0]         era_prod;
  logic [29:0]         a5_prod;
  logic [21:0]         c100_prod;
  logic signed [15:0]  y_w, era_w, yoe_full;
  logic [31:0]         b_days;

  // january and february count as months 13 and 14 of the previous year
  assign early     = (stamp.month <= 7'd2);
  // floor division by 400, 100 and 5 through reciprocal multiplies
  assign era_prod  = 28'(y_s[13:0]) * 28'd10486;
  assign a5_prod   = 30'(x5) * 30'd52429;
  assign c100_prod = 22'(yoe) * 22'd5243;
  assign y_w       = 16'(y_s);
  assign era_w     = 16'(era);
  assign yoe_full  = y_w - era_w * 16'sd400;
  assign b_days    = 32'(yoe) * 32'd365 + 32'(yoe[8:2]) - 32'(c100_prod[21:19]);

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (in_valid) begin
          state_next = BK_ERA;
        end
      end
      BK_ERA:  state_next = BK_YOE;
      BK_YOE:  state_next = BK_DOE;
      BK_DOE:  state_next = BK_DAYS;
      BK_DAYS: state_next = BK_MUL;
      BK_MUL:  state_next = BK_SUM;
      BK_SUM: begin
        if (!out_valid || out_ready) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == BK_IDLE);
    out_load = (state == BK_SUM) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (in_valid) begin
          rec  <= stamp;
          y_s  <= 15'({1'b0, stamp.year}) - 15'(early);
          madj <= early ? stamp.month + 7'd12 : stamp.month;
        end
      end
      BK_ERA: begin
        era <= y_s[14] ? -6'sd1 : $signed({1'b0, era_prod[26:22]});
        x5  <= 14'(madj - 7'd3) * 14'd153 + 14'd2;
      end
      BK_YOE: begin
        yoe <= yoe_full[8:0];
        a5  <= a5_prod[29:18];
      end
      BK_DOE: begin
        // day of era wraps as a 32-bit unsigned value
        doe  <= b_days + 32'(a5) + 32'(rec.day) - 32'd1;
        tsec <= 19'(rec.hour) * 19'd3600 + 19'(rec.minute) * 19'd60 + 19'(rec.second);
        case (rec.frac_digits)
          2'd1:    ms_frac <= rec.frac_ms * 10'd100;
          2'd2:    ms_frac <= rec.frac_ms * 10'd10;
          default: ms_frac <= rec.frac_ms;
        endcase
        off <= 13'(rec.zone_hours) * 13'd60 + 13'(rec.zone_minutes);
      end
      BK_DAYS: begin
        days <= 35'(era) * 35'sd146097 + $signed({3'b000, doe}) - 35'sd719468;
        if (rec.zone_neg) begin
          tms <= $signed(32'(tsec) * 32'd1000 + 32'(ms_frac) + 32'(off) * 32'd60000);
        end else begin
          tms <= $signed(32'(tsec) * 32'd1000 + 32'(ms_frac) - 32'(off) * 32'd60000);
        end
      end
      BK_MUL: begin
        prod <= 64'(days) * 64'sd86400000;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ok <= rec.ok;
      if (rec.ok) begin
        out_ms <= prod + 64'(tms);
      end else begin
        out_ms <= rec.fail_high ? FAIL_HIGH_VALUE : 64'd0;
      end
    end
  end

endmodule

[sv/iso8601_timestamp_to_epoch_ms_core.sv]
// the last character beat puts the parsed timestamp in the queue; the converter takes it
// from idle through era, yoe, doe, days, mul and sum states and registers the result beat
// throughput: one character per cycle while the queue has room; the converter takes one
// timestamp at a time; short strings or a stalled result side fill the queue, holding input
// reset: synchronous rst clears the parse position and fields, the queue and the
// result valid; the first character after reset starts a new timestamp
module iso8601_timestamp_to_epoch_ms_core import isots_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tlast,
  input  logic        s_tuser,   // [0] fail_high
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [63:0] epoch_ms
  output logic        m_tuser    // [0] parse_ok
);

  stamp_t front_stamp, back_stamp;
  logic   front_push, front_ready, back_valid, back_ready;

  isots_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .char_code  (s_tdata),
    .last_char  (s_tlast),
    .fail_high  (s_tuser),
    .push       (front_push),
    .stamp      (front_stamp),
    .push_ready (front_ready)
  );

  isots_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_push),
    .in_ready  (front_ready),
    .in_data   (front_stamp),
    .out_valid (back_valid),
    .out_ready (back_ready),
    .out_data  (back_stamp)
  );

  isots_convert u_convert (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (back_valid),
    .in_ready  (back_ready),
    .stamp     (back_stamp),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_ok    (m_tuser),
    .out_ms    (m_tdata)
  );

endmodule

[sim/iso8601_timestamp_to_epoch_ms_core_test.sv]
// self-checking testbench for the timestamp text to epoch milliseconds converter
`timescale 1ns / 100ps

module iso8601_timestamp_to_epoch_ms_core_test import isots_pkg::*; ();

  localparam int IDLE_LIMIT = 2000;
  localparam int CHAR_TARGET = 1600;
  localparam int STAMP_TARGET = 60;

  typedef logic [7:0] text_t[$];

  typedef struct {
    bit          ok;
    logic [63:0] ms;
  } epoch_t;

  // tracks the parse of each character stream and holds the epochs it predicts
  class epoch_scoreboard;
    phase_t             phase;
    logic [YEAR_W-1:0]  year;
    logic [FIELD_W-1:0] month, day, hour, minute, second, zone_hours, zone_minutes;
    logic [FRAC_W-1:0]  frac;
    logic [FDIG_W-1:0]  frac_digits;
    bit                 zone_neg, failed;
    epoch_t             pending_epochs[$];
    int                 errors, parsed, rejected;

    function new();
      restart_parse();
    endfunction

    function void restart_parse();
      phase = PH_Y0;
      year = '0;
      month = '0;
      day = '0;
      hour = '0;
      minute = '0;
      second = '0;
      frac = '0;
      frac_digits = '0;
      zone_neg = 1'b0;
      zone_hours = '0;
      zone_minutes = '0;
      failed = 1'b0;
    endfunction

    function bit take_zone_mark(logic [7:0] ch);
      if (ch == CH_Z) begin
        phase = PH_DONE;
        return 1'b1;
      end
      if (ch == CH_PLUS || ch == CH_DASH) begin
        zone_neg = (ch == CH_DASH);
        phase = PH_ZH0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function bit take_char(logic [7:0] ch);
      bit         dig;
      logic [3:0] dv;
      dig = (ch >= CH_ZERO && ch <= CH_NINE);
      dv = 4'(ch - CH_ZERO);
      case (phase)
        PH_Y0, PH_Y1, PH_Y2, PH_Y3: begin
          if (!dig) return 1'b0;
          year = YEAR_W'(year * 10 + dv);
        end
        PH_DASH1, PH_DASH2: if (ch != CH_DASH) return 1'b0;
        PH_MO0, PH_MO1: begin
          if (!dig) return 1'b0;
          month = FIELD_W'(month * 10 + dv);
        end
        PH_D0, PH_D1: begin
          if (!dig) return 1'b0;
          day = FIELD_W'(day * 10 + dv);
        end
        PH_T: if (ch != CH_T) return 1'b0;
        PH_H0, PH_H1: begin
          if (!dig) return 1'b0;
          hour = FIELD_W'(hour * 10 + dv);
        end
        PH_COLON1, PH_COLON2, PH_ZCOLON: if (ch != CH_COLON) return 1'b0;
        PH_MI0, PH_MI1: begin
          if (!dig) return 1'b0;
          minute = FIELD_W'(minute * 10 + dv);
        end
        PH_S0, PH_S1: begin
          if (!dig) return 1'b0;
          second = FIELD_W'(second * 10 + dv);
        end
        PH_SEP: begin
          if (ch == CH_DOT) begin
            phase = PH_FRAC0;
            return 1'b1;
          end
          return take_zone_mark(ch);
        end
        PH_FRAC0, PH_FRAC: begin
          if (dig) begin
            // digits past the third are checked but dropped
            if (frac_digits < FRAC_DIGITS_MAX) begin
              frac = FRAC_W'(frac * 10 + dv);
              frac_digits++;
            end
            phase = PH_FRAC;
            return 1'b1;
          end
          if (phase == PH_FRAC0) return 1'b0;
          return take_zone_mark(ch);
        end
        PH_ZH0, PH_ZH1: begin
          if (!dig) return 1'b0;
          zone_hours = FIELD_W'(zone_hours * 10 + dv);
        end
        PH_ZM0, PH_ZM1: begin
          if (!dig) return 1'b0;
          zone_minutes = FIELD_W'(zone_minutes * 10 + dv);
        end
        default: return 1'b0;
      endcase
      phase = phase_t'(phase + 1);
      return 1'b1;
    endfunction

    function void note_char(logic [7:0] ch, bit last, bit high);
      epoch_t      e;
      longint      y, era, days, frac_scaled, off;
      logic [31:0] m, yoe, doy, doe;
      if (!failed && !take_char(ch)) failed = 1'b1;
      if (!last) return;
      e.ok = !failed && phase == PH_DONE;
      if (e.ok) begin
        y = longint'(year);
        m = 32'(month);
        if (m <= 32'd2) begin
          y = y - 1;
          m = m + 32'd12;
        end
        era = (y >= 0 ? y : y - 399) / 400;
        // date terms wrap as 32-bit unsigned, day zero included
        yoe = 32'(y - era * 400);
        doy = (32'd153 * (m - 32'd3) + 32'd2) / 32'd5 + 32'(day) - 32'd1;
        doe = yoe * 32'd365 + yoe / 32'd4 - yoe / 32'd100 + doy;
        days = era * 146097 + longint'({32'd0, doe}) - 719468;
        frac_scaled = longint'(frac);
        if (frac_digits == 2'd1) frac_scaled = frac_scaled * 100;
        else if (frac_digits == 2'd2) frac_scaled = frac_scaled * 10;
        off = longint'(zone_hours) * 60 + longint'(zone_minutes);
        if (zone_neg) off = -off;
        e.ms = 64'(days * 86400000
                   + (longint'(hour) * 3600 + longint'(minute) * 60 + longint'(second)) * 1000
                   + frac_scaled - off * 60000);
        parsed++;
      end else begin
        e.ms = high ? FAIL_HIGH_VALUE : 64'd0;
        rejected++;
      end
      pending_epochs.push_back(e);
      restart_parse();
    endfunction

    function void check_epoch(bit ok, logic [63:0] ms);
      epoch_t e;
      if (pending_epochs.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual parse_ok=%0b epoch_ms=%0d",
                 $time, ok, $signed(ms));
        return;
      end
      e = pending_epochs.pop_front();
      if (ok !== e.ok) begin
        errors++;
        $display("%0t: parse_ok mismatch, expected %0b actual %0b", $time, e.ok, ok);
      end
      if (ms !== e.ms) begin
        errors++;
        $display("%0t: epoch_ms mismatch, expected %0d actual %0d",
                 $time, $signed(e.ms), $signed(ms));
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tuser;

  epoch_scoreboard sb = new();
  bit no_idle = 1'b0;
  int chars_sent = 0;
  int stamps_sent = 0;
  int idle_cycles = 0;

  iso8601_timestamp_to_epoch_ms_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #6 clk = ~clk;

  // both handshakes are sampled here with the values that stood at the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_epoch(m_tuser, m_tdata);
      if (s_tvalid && s_tready) sb.note_char(s_tdata, s_tlast, s_tuser);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : result_sink
    int stall;
    wait (rst == 1'b0);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  function automatic text_t text_of(string str);
    text_t t;
    for (int i = 0; i < str.len(); i++) t.push_back(str[i]);
    return t;
  endfunction

  function automatic text_t decimal_text(int unsigned value, int n);
    text_t t;
    repeat (n) begin
      t.push_front(8'(CH_ZERO + value % 10));
      value = value / 10;
    end
    return t;
  endfunction

  // mostly in the usual range, sometimes anything two digits can hold
  function automatic int unsigned field_value(int unsigned lo, int unsigned hi);
    return ($urandom_range(0, 6) == 0) ? $urandom_range(0, 99) : $urandom_range(lo, hi);
  endfunction

  function automatic text_t random_stamp();
    text_t t;
    int    n;
    case ($urandom_range(0, 9))
      0: t = decimal_text(0, 4);
      1: t = decimal_text(9999, 4);
      default: t = decimal_text($urandom_range(0, 9999), 4);
    endcase
    t.push_back(CH_DASH);
    t = {t, decimal_text(field_value(1, 12), 2)};
    t.push_back(CH_DASH);
    t = {t, decimal_text(field_value(1, 31), 2)};
    t.push_back(CH_T);
    t = {t, decimal_text(field_value(0, 23), 2)};
    t.push_back(CH_COLON);
    t = {t, decimal_text(field_value(0, 59), 2)};
    t.push_back(CH_COLON);
    t = {t, decimal_text(field_value(0, 59), 2)};
    n = $urandom_range(0, 1) ? 0 : $urandom_range(1, 5);
    if (n > 0) begin
      t.push_back(CH_DOT);
      t = {t, decimal_text($urandom, n)};
    end
    if ($urandom_range(0, 2) == 0) begin
      t.push_back(CH_Z);
    end else begin
      t.push_back($urandom_range(0, 1) ? CH_PLUS : CH_DASH);
      t = {t, decimal_text(field_value(0, 14), 2)};
      t.push_back(CH_COLON);
      t = {t, decimal_text(field_value(0, 59), 2)};
    end
    return t;
  endfunction

  // valid stays up between back-to-back beats, dropped only for a gap
  task automatic send_char(input logic [7:0] ch, input bit last, input bit high);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tlast  <= last;
    s_tuser  <= high;
    do @(posedge clk); while (!s_tready);
    chars_sent++;
  endtask

  // fail_high only counts on the last beat, so the others carry noise
  task automatic send_stamp(input text_t s, input bit high);
    foreach (s[i]) begin
      send_char(s[i], i == s.size() - 1, (i == s.size() - 1) ? high : 1'($urandom));
    end
    stamps_sent++;
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending_epochs.size() != 0);
  endtask

  initial begin : stimulus
    text_t raw;
    bit    high;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    no_idle = 1'b1;
    send_stamp(text_of("1970-01-01T00:00:00Z"), 1'b0);
    send_stamp(text_of("0000-01-01T00:00:00Z"), 1'b1);
    send_stamp(text_of("9999-12-31T23:59:59.999Z"), 1'b0);
    no_idle = 1'b0;
    send_stamp(text_of("2024-02-29T12:34:56.5+05:30"), 1'b0);
    send_stamp(text_of("2000-03-01T00:00:00.25-11:45"), 1'b1);
    send_stamp(text_of("1999-99-99T99:99:99.12345-99:99"), 1'b0);
    send_stamp(text_of("2001-00-00T00:00:00Z"), 1'b0);
    send_stamp(text_of("1969-12-31T23:59:59.001+00:00"), 1'b0);
    // dot without digits, cut short, trailing junk, bad digit, unfinished zone
    send_stamp(text_of("2024-06-15T08:00:00.Z"), 1'b1);
    send_stamp(text_of("2024-06-15T08:00"), 1'b1);
    send_stamp(text_of("2024-06-15T08:00:00Zx"), 1'b0);
    send_stamp(text_of("20X4-06-15T08:00:00Z"), 1'b1);
    send_stamp(text_of("2024-06-15T08:00:00+05"), 1'b1);
    raw.push_back(8'h00);
    send_stamp(raw, 1'b0);
    raw[0] = 8'hFF;
    send_stamp(raw, 1'b1);
    wait_for_results();

    while (chars_sent < CHAR_TARGET || stamps_sent < STAMP_TARGET) begin
      no_idle = ($urandom_range(0, 4) == 0);
      high = 1'($urandom);
      raw = random_stamp();
      case ($urandom_range(0, 9))
        6: raw[$urandom_range(0, raw.size() - 1)] = 8'($urandom);
        7: repeat ($urandom_range(1, raw.size() - 1)) void'(raw.pop_back());
        8: repeat ($urandom_range(1, 3)) raw.push_back(8'($urandom));
        9: begin
          raw.delete();
          repeat ($urandom_range(1, 30)) raw.push_back(8'($urandom));
        end
        default: ;
      endcase
      send_stamp(raw, high);
      if (stamps_sent % 20 == 0) wait_for_results();
    end

    no_idle = 1'b0;
    wait_for_results();
    repeat (24) @(posedge clk);

    if (sb.pending_epochs.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending_epochs.size());
    end
    $display("%0d timestamps over %0d character beats, %0d valid and %0d rejected",
             stamps_sent, chars_sent, sb.parsed, sb.rejected);
    $display("mix of field extremes, fractions, zones, broken and noise strings, random stalls");
    if (sb.errors == 0 && sb.pending_epochs.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
